// ----- rtl/thermal_alarm_state_machine_defines.svh -----
// Assertion macros shared by the thermal alarm checker.
`ifndef THERMAL_ALARM_STATE_MACHINE_DEFINES_SVH
`define THERMAL_ALARM_STATE_MACHINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tas_pkg.sv -----
// Shared types and constants for the thermal alarm block.
package tas_pkg;

    // Field widths
    localparam int MDEG_W  = 18;
    localparam int DEG_W   = 9;
    localparam int CFG_W   = 9;
    localparam int NUM_LIMITS = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_LIMITS);

    typedef logic [MDEG_W-1:0]      mdeg_t;
    typedef logic signed [DEG_W-1:0] deg_t;
    typedef logic signed [CFG_W-1:0] limit_t;
    typedef limit_t                  limit_arr_t [NUM_LIMITS];

    // Limit register indexes
    localparam int REG_DIGITAL_WARN = 0;
    localparam int REG_DIGITAL_CRIT = 1;
    localparam int REG_RF_WARN      = 2;
    localparam int REG_RF_CRIT      = 3;
    localparam int REG_PA_WARN      = 4;
    localparam int REG_PA_CRIT      = 5;
    localparam int REG_BOARD_WARN   = 6;
    localparam int REG_BOARD_CRIT   = 7;

    localparam limit_t LIMIT_RESET [NUM_LIMITS] = '{
        9'sd70, 9'sd80, 9'sd70, 9'sd80, 9'sd70, 9'sd80, 9'sd70, 9'sd80
    };

    // PA/board pair status codes
    localparam logic [1:0] EXTRA_ABSENT = 2'd0;
    localparam logic [1:0] EXTRA_OK     = 2'd1;
    localparam logic [1:0] EXTRA_FAIL   = 2'd2;

    // Alarm state codes as seen on the result port
    localparam logic [1:0] ALARM_NORMAL    = 2'd0;
    localparam logic [1:0] ALARM_WARN_HYST = 2'd1;
    localparam logic [1:0] ALARM_WARNING   = 2'd2;
    localparam logic [1:0] ALARM_CRITICAL  = 2'd3;

    // Millidegree to degree: multiply by a rounded-up reciprocal and shift.
    // Exact for every 18-bit input since x * (M*1000 - 2^S) < 2^S.
    localparam int MILLI_PER_DEG = 1000;
    localparam int RECIP_SHIFT   = 28;
    localparam int RECIP_M = ((1 << RECIP_SHIFT) + MILLI_PER_DEG - 1) / MILLI_PER_DEG;
    localparam int RECIP_W = $clog2(RECIP_M + 1);
    localparam int PROD_W  = MDEG_W + RECIP_W;
    localparam int QUOT_W  = 9;   // 262143 / 1000 = 262 fits in 9 bits

    // Threshold results of one check
    typedef struct packed {
        logic warn;
        logic crit;
    } flags_t;

endpackage

// ----- rtl/tas_deg_conv.sv -----
// Millidegree to whole-degree conversion by reciprocal multiplication.
module tas_deg_conv (
    input  tas_pkg::mdeg_t             millideg,
    output logic [tas_pkg::QUOT_W-1:0] deg
);
    import tas_pkg::*;

    logic [PROD_W-1:0] prod;

    // Truncating divide by 1000
    assign prod = PROD_W'(millideg) * PROD_W'(RECIP_M);
    assign deg  = prod[RECIP_SHIFT +: QUOT_W];

endmodule

// ----- rtl/tas_limit_check.sv -----
// Compares all readings of one check against their limits.
module tas_limit_check (
    input  tas_pkg::mdeg_t     digital_millideg,
    input  logic               digital_ok,
    input  tas_pkg::mdeg_t     rf_millideg,
    input  logic               rf_ok,
    input  logic [1:0]         extra_status,
    input  tas_pkg::deg_t      pa_deg,
    input  tas_pkg::deg_t      board_deg,
    input  tas_pkg::limit_arr_t limits,
    output tas_pkg::flags_t    flags
);
    import tas_pkg::*;

    logic [QUOT_W-1:0]   digital_deg;
    logic [QUOT_W-1:0]   rf_deg;
    logic signed [QUOT_W:0] digital_s;
    logic signed [QUOT_W:0] rf_s;
    logic signed [QUOT_W:0] pa_s;
    logic signed [QUOT_W:0] board_s;
    flags_t digital_f;
    flags_t rf_f;
    flags_t extra_f;

    // Strictly-above test on a 10-bit signed scale
    function automatic logic above(input logic signed [QUOT_W:0] val, input limit_t lim);
        logic signed [QUOT_W:0] lim_x;
        lim_x = {lim[CFG_W-1], lim};
        return val > lim_x;
    endfunction

    tas_deg_conv u_digital_conv (
        .millideg (digital_millideg),
        .deg      (digital_deg)
    );

    tas_deg_conv u_rf_conv (
        .millideg (rf_millideg),
        .deg      (rf_deg)
    );

    assign digital_s = {1'b0, digital_deg};
    assign rf_s      = {1'b0, rf_deg};
    assign pa_s      = {pa_deg[DEG_W-1], pa_deg};
    assign board_s   = {board_deg[DEG_W-1], board_deg};

    // Per-source flags; a failed read forces both
    always_comb
    begin
        digital_f.warn = !digital_ok || above(digital_s, limits[REG_DIGITAL_WARN]);
        digital_f.crit = !digital_ok || above(digital_s, limits[REG_DIGITAL_CRIT]);
        rf_f.warn      = !rf_ok || above(rf_s, limits[REG_RF_WARN]);
        rf_f.crit      = !rf_ok || above(rf_s, limits[REG_RF_CRIT]);

        case (extra_status)
            EXTRA_ABSENT:
            begin
                extra_f = '0;
            end
            EXTRA_OK:
            begin
                extra_f.warn = above(pa_s, limits[REG_PA_WARN])
                            || above(board_s, limits[REG_BOARD_WARN]);
                extra_f.crit = above(pa_s, limits[REG_PA_CRIT])
                            || above(board_s, limits[REG_BOARD_CRIT]);
            end
            default:
            begin
                // failed read, and the unused code treated the same
                extra_f = '1;
            end
        endcase

        flags = digital_f | rf_f | extra_f;
    end

endmodule

// ----- rtl/tas_fsm.sv -----
// Hysteresis state machine and result register.
module tas_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  tas_pkg::flags_t flags,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [1:0]      alarm_state,
    output logic            state_changed,
    output logic            warn_seen,
    output logic            crit_seen
);
    import tas_pkg::*;

    typedef enum logic [1:0] {
        ST_NORMAL    = ALARM_NORMAL,
        ST_WARN_HYST = ALARM_WARN_HYST,
        ST_WARNING   = ALARM_WARNING,
        ST_CRITICAL  = ALARM_CRITICAL
    } state_t;

    state_t state_reg, state_next;
    logic   changed_reg, warn_reg, crit_reg, valid_reg;

    // Next state from the current state and this check's flags
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_NORMAL:
            begin
                if (flags.crit)
                    state_next = ST_CRITICAL;
                else if (flags.warn)
                    state_next = ST_WARNING;
            end
            ST_WARN_HYST:
            begin
                if (flags.crit)
                    state_next = ST_CRITICAL;
                else if (flags.warn)
                    state_next = ST_WARNING;
                else
                    state_next = ST_NORMAL;
            end
            ST_WARNING:
            begin
                if (flags.crit)
                    state_next = ST_CRITICAL;
                else if (!flags.warn)
                    state_next = ST_WARN_HYST;
            end
            ST_CRITICAL:
            begin
                if (!flags.crit && !flags.warn)
                    state_next = ST_WARNING;
            end
            default:
            begin
                state_next = ST_NORMAL;
            end
        endcase
    end

    // State and result register; the state itself is the reported state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_NORMAL;
            changed_reg <= 1'b0;
            warn_reg    <= 1'b0;
            crit_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            // hysteresis state always moves on
            changed_reg <= (state_next != state_reg) || (state_reg == ST_WARN_HYST);
            warn_reg    <= flags.warn;
            crit_reg    <= flags.crit;
            valid_reg   <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid     = valid_reg;
    assign alarm_state   = state_reg;
    assign state_changed = changed_reg;
    assign warn_seen     = warn_reg;
    assign crit_seen     = crit_reg;

endmodule

// ----- rtl/thermal_alarm_state_machine.sv -----
// Top level of the thermal alarm: limit registers, input register, state step.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------------
//  in        in_valid/in_ready    digital_millideg, digital_ok, rf_millideg, rf_ok,
//                                 extra_status, pa_deg, board_deg
//  out       out_valid/out_ready  alarm_state, state_changed, warn_seen, crit_seen
//  cfg       cfg_we               cfg_index, cfg_data (write only, no wait)
//
//  One transaction per cycle sustained while out_ready is high; each input goes
//  through the input register, then the result register that also holds the state.
//  Between them sit two parallel 18x19 reciprocal multiplies, the limit compares and
//  the 2-bit state step. Reset puts the state at normal and all limits at defaults.
//  A stall on out holds the result; with both registers full it also drops in_ready.
module thermal_alarm_state_machine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  tas_pkg::limit_t               cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tas_pkg::mdeg_t                digital_millideg,
    input  logic                          digital_ok,
    input  tas_pkg::mdeg_t                rf_millideg,
    input  logic                          rf_ok,
    input  logic [1:0]                    extra_status,
    input  tas_pkg::deg_t                 pa_deg,
    input  tas_pkg::deg_t                 board_deg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    alarm_state,
    output logic                          state_changed,
    output logic                          warn_seen,
    output logic                          crit_seen
);
    import tas_pkg::*;

    limit_arr_t limits_reg;

    logic       s1_valid_reg;
    mdeg_t      digital_mdeg_reg;
    logic       digital_ok_reg;
    mdeg_t      rf_mdeg_reg;
    logic       rf_ok_reg;
    logic [1:0] extra_status_reg;
    deg_t       pa_deg_reg;
    deg_t       board_deg_reg;

    logic       step;
    logic       in_take;
    flags_t     flags;

    // Handshake: the input register moves on whenever the result register is free
    assign step     = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LIMITS; i++)
                limits_reg[i] <= LIMIT_RESET[i];
        end
        else if (cfg_we)
        begin
            limits_reg[cfg_index] <= cfg_data;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            digital_mdeg_reg <= digital_millideg;
            digital_ok_reg   <= digital_ok;
            rf_mdeg_reg      <= rf_millideg;
            rf_ok_reg        <= rf_ok;
            extra_status_reg <= extra_status;
            pa_deg_reg       <= pa_deg;
            board_deg_reg    <= board_deg;
        end
    end

    tas_limit_check u_check (
        .digital_millideg (digital_mdeg_reg),
        .digital_ok       (digital_ok_reg),
        .rf_millideg      (rf_mdeg_reg),
        .rf_ok            (rf_ok_reg),
        .extra_status     (extra_status_reg),
        .pa_deg           (pa_deg_reg),
        .board_deg        (board_deg_reg),
        .limits           (limits_reg),
        .flags            (flags)
    );

    tas_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .flags         (flags),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .alarm_state   (alarm_state),
        .state_changed (state_changed),
        .warn_seen     (warn_seen),
        .crit_seen     (crit_seen)
    );

endmodule

// ----- rtl/tas_checker.sv -----
// Port-level checks on the thermal alarm results, bound to the top level.
`include "thermal_alarm_state_machine_defines.svh"

module tas_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] alarm_state,
    input logic       state_changed,
    input logic       warn_seen,
    input logic       crit_seen
);
    import tas_pkg::*;

    // A stalled result holds its state
    `TAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(alarm_state), "result changed while stalled")

    // Normal is only reached or kept with a clean check
    `TAS_ASSERT_NOW(a_normal_clean, out_valid && alarm_state == ALARM_NORMAL, !warn_seen && !crit_seen, "normal state with a flag set")

    // Hysteresis is entered from warning by a clean check, always a move
    `TAS_ASSERT_NOW(a_hyst_entry, out_valid && alarm_state == ALARM_WARN_HYST, state_changed && !warn_seen && !crit_seen, "bad entry to warning hysteresis")

    // Any critical flag lands in critical
    `TAS_ASSERT_NOW(a_crit_state, out_valid && crit_seen, alarm_state == ALARM_CRITICAL, "critical flag without critical state")

    // Critical is held only while some flag remains
    `TAS_ASSERT_NOW(a_crit_flags, out_valid && alarm_state == ALARM_CRITICAL, warn_seen || crit_seen, "critical state with no flag")

endmodule

bind thermal_alarm_state_machine tas_checker u_tas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .alarm_state   (alarm_state),
    .state_changed (state_changed),
    .warn_seen     (warn_seen),
    .crit_seen     (crit_seen)
);
